// File: hw/rtl/lsfs_pkg.sv
`timescale 1ns / 1ps

package lsfs_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_LED   = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
   localparam logic [1:0] REG_LED_COUNT  = 2'd1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int BRIGHT_W    = 5;
   localparam int COUNT_W     = 7;
   localparam int FRAME_W     = 32;
   localparam int LEN_W       = 7;

   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd31;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 7'd64;
   localparam logic [2:0]          LED_HEADER   = 3'b111;
   localparam logic [LEN_W-1:0]    FRAME_LEN    = 7'd32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] color_first;
      logic [7:0] color_second;
      logic [7:0] color_third;
   } req_type;

   typedef struct packed {
      logic data_bit;
      logic last_bit;
   } rsp_type;

   // one queued frame run: bits to shift (MSB first, zero fill after) and run length
   typedef struct packed {
      logic [FRAME_W-1:0] word;
      logic [LEN_W-1:0]   len;
   } desc_type;

endpackage

// File: hw/rtl/lsfs_front.sv
`timescale 1ns / 1ps

module lsfs_front
   import lsfs_pkg::*;
#(
   parameter int MAX_LEDS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  req_type                req_data,
   output logic                   q_push,
   output desc_type               q_desc
);

   localparam int CLAMP_INT = (MAX_LEDS > 127) ? 127 : MAX_LEDS;
   localparam logic [COUNT_W-1:0] LED_CLAMP = COUNT_W'(CLAMP_INT);

   logic [BRIGHT_W-1:0] brightness_ff, brightness_in;
   logic [COUNT_W-1:0]  led_count_ff, led_count_in;
   logic [COUNT_W-1:0]  leds;
   logic [COUNT_W:0]    leds_round;
   logic [3:0]          groups;

   always_comb begin
      brightness_in = brightness_ff;
      led_count_in  = led_count_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BRIGHTNESS: brightness_in = csr_wdata[BRIGHT_W-1:0];
            REG_LED_COUNT:  led_count_in  = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHT_RESET;
         led_count_ff  <= COUNT_RESET;
      end else begin
         brightness_ff <= brightness_in;
         led_count_ff  <= led_count_in;
      end
   end

   // end frame: 8 zero bits per started group of 16 LEDs
   assign leds       = (led_count_ff > LED_CLAMP) ? LED_CLAMP : led_count_ff;
   assign leds_round = {1'b0, leds} + (COUNT_W + 1)'(15);
   assign groups     = leds_round[COUNT_W:4];

   always_comb begin
      q_push      = 1'b0;
      q_desc.word = '0;
      q_desc.len  = FRAME_LEN;
      case (req_data.cmd)
         CMD_START: q_push = req_valid;
         CMD_LED: begin
            q_push      = req_valid;
            q_desc.word = {LED_HEADER, brightness_ff, req_data.color_first,
                           req_data.color_second, req_data.color_third};
         end
         CMD_END: begin
            q_push     = req_valid;
            q_desc.len = FRAME_LEN + {groups, 3'b000};
         end
         default: ;  // unused code: drop
      endcase
   end

endmodule

// File: hw/rtl/lsfs_queue.sv
`timescale 1ns / 1ps

module lsfs_queue
   import lsfs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     nonempty,
   output desc_type head
);

   desc_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> nonempty)
      else $error("pop from empty queue");

endmodule

// File: hw/rtl/lsfs_back.sv
`timescale 1ns / 1ps

module lsfs_back
   import lsfs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_nonempty,
   input  desc_type q_head,
   output logic     q_pop,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_data
);

   logic               busy_ff, busy_in;
   logic [FRAME_W-1:0] shift_ff, shift_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               advance;
   logic               run_done;

   assign advance  = busy_ff && (!out_valid_ff || pop);
   assign run_done = advance && (remain_ff == LEN_W'(1));
   assign q_pop    = q_nonempty && (!busy_ff || run_done);

   always_comb begin
      busy_in      = busy_ff;
      shift_in     = shift_ff;
      remain_in    = remain_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in    = 1'b1;
         out_in.data_bit = shift_ff[FRAME_W-1];
         out_in.last_bit = run_done;
         shift_in        = {shift_ff[FRAME_W-2:0], 1'b0};
         remain_in       = remain_ff - 1'b1;
         busy_in         = !run_done;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
      // load the next run straight behind the last bit of this one
      if (q_pop) begin
         busy_in   = 1'b1;
         shift_in  = q_head.word;
         remain_in = q_head.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      remain_ff <= remain_in;
      out_ff    <= out_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   a_busy_len: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (remain_ff != '0))
      else $error("busy with no bits left");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      run_done |=> (out_valid_ff && out_ff.last_bit))
      else $error("final bit not marked");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (advance && !run_done) |=> (remain_ff == $past(remain_ff) - 1'b1))
      else $error("bit counter skipped");

endmodule

// File: hw/rtl/led_strip_frame_serializer.sv
`timescale 1ns / 1ps

// Frame serializer for a two-wire addressable LED strip.
// Requests enter through push/full as req_data (cmd and three colour bytes);
// a request is taken on a clock edge with push high and full low. cmd 0 gives
// a 32-bit zero start frame, cmd 1 an LED frame (111, brightness, colour bytes
// first/second/third), cmd 2 a 32-bit zero end frame plus 8 zero bits per
// started group of 16 LEDs; cmd 3 is taken and dropped.
// Results leave one data bit per entry through empty/pop, MSB first; last_bit
// marks the final bit of each request's run.
// A request's bits pass from its queue entry through the back-end shift
// register and the output register to rsp_data. Throughput: one bit per cycle
// while the output is not stalled; start and LED runs are 32 bits, end runs
// 32 + 8 * groups bits (at most 96). Runs follow each other with no gap.
// A two-entry queue between front end and back end keeps taking requests
// while the receiver stalls; full rises once both entries wait behind the
// run in progress. Reset empties everything and sets brightness to 31 and
// LED count to 64. Write csr_* only while idle.

module led_strip_frame_serializer
   import lsfs_pkg::*;
#(
   parameter int MAX_LEDS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   push,
   output logic                   full,
   input  req_type                req_data,
   output logic                   empty,
   input  logic                   pop,
   output rsp_type                rsp_data
);

   logic     front_push;
   desc_type front_desc;
   logic     q_pop;
   logic     q_nonempty;
   desc_type q_head;

   // classify the request and build the frame descriptor
   lsfs_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (push && !full),
      .req_data  (req_data),
      .q_push    (front_push),
      .q_desc    (front_desc)
   );

   // decouple front end from the serializer
   lsfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_desc (front_desc),
      .pop       (q_pop),
      .full      (full),
      .nonempty  (q_nonempty),
      .head      (q_head)
   );

   // shift out one bit per cycle into the output register while it is free or popped
   lsfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule
